### rtl/ofg_pkg.sv
// ----------------------------------------------------------------------------
// ofg_pkg
// Shared types, codes and defaults for the observation freshness guard.
// ----------------------------------------------------------------------------
package ofg_pkg;

  // default widths of the time, age and streak fields
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned AGE_BITS_DEF    = 32;
  localparam int unsigned STREAK_BITS_DEF = 8;

  // configuration register widths
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned RCNT_W  = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_A_W = 2;

  // configuration reset values
  localparam logic [LIMIT_W-1:0] FRESH_LIMIT_RST    = 32'd100000;
  localparam logic [LIMIT_W-1:0] FALLBACK_LIMIT_RST = 32'd0;
  localparam logic [RCNT_W-1:0]  RECOVERY_COUNT_RST = 8'd1;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_FRESH_LIMIT    = 2'd0,
    CFG_FALLBACK_LIMIT = 2'd1,
    CFG_RECOVERY_COUNT = 2'd2
  } cfg_idx_e;

  // item kinds
  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_RESUME = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // guard modes
  typedef enum logic [2:0] {
    MODE_WAITING   = 3'd0,
    MODE_LIVE      = 3'd1,
    MODE_HOLD      = 3'd2,
    MODE_FALLBACK  = 3'd3,
    MODE_RECOVERED = 3'd4
  } mode_e;

  // single-bit status that goes with each result
  typedef struct packed {
    logic resume_ok;
    logic pose_held;
    logic latched;
  } flags_t;

endpackage

### rtl/ofg_core.sv
// ----------------------------------------------------------------------------
// ofg_core
// Guard state and the per-item update: freshness test, stale time, mode
// choice, fallback latch, recovery streak, resume and clear.
// ----------------------------------------------------------------------------
module ofg_core #(
  parameter int unsigned TIME_BITS   = ofg_pkg::TIME_BITS_DEF,
  parameter int unsigned AGE_BITS    = ofg_pkg::AGE_BITS_DEF,
  parameter int unsigned STREAK_BITS = ofg_pkg::STREAK_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // one item is processed in a cycle with en_i high
  input  logic                        en_i,
  input  logic [1:0]                  kind_i,
  input  logic [TIME_BITS-1:0]        now_time_i,
  input  logic                        pose_present_i,
  input  logic                        age_valid_i,
  input  logic [AGE_BITS-1:0]         pose_age_i,
  input  logic [ofg_pkg::LIMIT_W-1:0] fresh_limit_i,
  input  logic [ofg_pkg::LIMIT_W-1:0] fallback_limit_i,
  input  logic [ofg_pkg::RCNT_W-1:0]  recovery_count_i,
  // status after the item
  output ofg_pkg::mode_e              mode_o,
  output logic [AGE_BITS-1:0]         stale_time_o,
  output logic [STREAK_BITS-1:0]      fresh_streak_o,
  output ofg_pkg::flags_t             flags_o
);

  // common compare width
  localparam int unsigned CW0 = (TIME_BITS > AGE_BITS) ? TIME_BITS : AGE_BITS;
  localparam int unsigned CW  = (CW0 > ofg_pkg::LIMIT_W) ? CW0 : ofg_pkg::LIMIT_W;
  localparam int unsigned SW  = (STREAK_BITS > ofg_pkg::RCNT_W) ? STREAK_BITS
                                                                : ofg_pkg::RCNT_W;
  localparam logic [CW-1:0] AgeMax = CW'({AGE_BITS{1'b1}});

  logic                   pose_cached_q, pose_cached_d;
  logic                   ftv_q, ftv_d;
  logic [TIME_BITS-1:0]   last_q, last_d;
  logic                   latch_q, latch_d;
  logic [STREAK_BITS-1:0] streak_q, streak_d;
  ofg_pkg::mode_e         mode_q, mode_d;
  logic [AGE_BITS-1:0]    stale_q, stale_d;
  logic                   resume_ok;

  // widened operands
  logic [CW-1:0] now_x, age_x, fl_x, fb_x, last_x;
  logic          fresh, fb_en, set_time, age_gt_now;
  logic [CW-1:0] stale_full;
  logic [STREAK_BITS-1:0] streak_inc;

  assign now_x  = CW'(now_time_i);
  assign age_x  = CW'(pose_age_i);
  assign fl_x   = CW'(fresh_limit_i);
  assign fb_x   = CW'(fallback_limit_i);
  assign last_x = CW'(last_q);

  // freshness and stale-time terms, all in parallel
  assign fresh      = pose_present_i && age_valid_i && (age_x <= fl_x);
  assign fb_en      = (fallback_limit_i != '0);
  assign set_time   = fresh || (!ftv_q && pose_present_i && age_valid_i);
  assign age_gt_now = (age_x > now_x);
  assign streak_inc = (streak_q == {STREAK_BITS{1'b1}}) ? streak_q
                                                        : streak_q + 1'b1;

  // a fresh time set this item gives stale = now - (now - age), clamped
  always_comb begin
    if (set_time) begin
      stale_full = age_gt_now ? now_x : age_x;
    end else if (ftv_q) begin
      stale_full = (now_x >= last_x) ? (now_x - last_x) : '0;
    end else begin
      stale_full = fb_en ? fb_x : '0;
    end
  end

  // next state
  always_comb begin
    pose_cached_d = pose_cached_q;
    ftv_d         = ftv_q;
    last_d        = last_q;
    latch_d       = latch_q;
    streak_d      = streak_q;
    mode_d        = mode_q;
    stale_d       = stale_q;
    resume_ok     = 1'b0;
    case (ofg_pkg::kind_e'(kind_i))
      ofg_pkg::KIND_UPDATE: begin
        if (pose_present_i) begin
          pose_cached_d = 1'b1;
        end
        if (set_time) begin
          last_d = age_gt_now ? '0 : TIME_BITS'(now_x - age_x);
          ftv_d  = 1'b1;
        end
        stale_d = (stale_full > AgeMax) ? {AGE_BITS{1'b1}} : AGE_BITS'(stale_full);
        if (latch_q) begin
          streak_d = fresh ? streak_inc : '0;
          mode_d   = (SW'(streak_d) >= SW'(recovery_count_i)) ? ofg_pkg::MODE_RECOVERED
                                                              : ofg_pkg::MODE_FALLBACK;
        end else begin
          streak_d = '0;
          if (fresh) begin
            mode_d = ofg_pkg::MODE_LIVE;
          end else if (pose_cached_d && (!fb_en || stale_full <= fb_x)) begin
            mode_d = ofg_pkg::MODE_HOLD;
          end else if (fb_en) begin
            latch_d = 1'b1;
            mode_d  = ofg_pkg::MODE_FALLBACK;
          end else begin
            mode_d = ofg_pkg::MODE_WAITING;
          end
        end
      end
      ofg_pkg::KIND_RESUME: begin
        if (latch_q && mode_q == ofg_pkg::MODE_RECOVERED) begin
          latch_d   = 1'b0;
          streak_d  = '0;
          stale_d   = '0;
          mode_d    = ofg_pkg::MODE_LIVE;
          resume_ok = 1'b1;
        end
      end
      ofg_pkg::KIND_CLEAR: begin
        pose_cached_d = 1'b0;
        ftv_d         = 1'b0;
        last_d        = '0;
        latch_d       = 1'b0;
        streak_d      = '0;
        mode_d        = ofg_pkg::MODE_WAITING;
        stale_d       = '0;
      end
      default: begin
        // unused kind leaves everything as it is
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_cached_q <= 1'b0;
      ftv_q         <= 1'b0;
      last_q        <= '0;
      latch_q       <= 1'b0;
      streak_q      <= '0;
      mode_q        <= ofg_pkg::MODE_WAITING;
      stale_q       <= '0;
    end else if (en_i) begin
      pose_cached_q <= pose_cached_d;
      ftv_q         <= ftv_d;
      last_q        <= last_d;
      latch_q       <= latch_d;
      streak_q      <= streak_d;
      mode_q        <= mode_d;
      stale_q       <= stale_d;
    end
  end

  // status after the item
  assign mode_o            = mode_d;
  assign stale_time_o      = stale_d;
  assign fresh_streak_o    = streak_d;
  assign flags_o.resume_ok = resume_ok;
  assign flags_o.pose_held = pose_cached_d;
  assign flags_o.latched   = latch_d;

  // latch only lives in fallback or recovered wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (mode_q == ofg_pkg::MODE_FALLBACK || mode_q == ofg_pkg::MODE_RECOVERED))
    else $error("latch set outside fallback and recovered wait");

  // the streak only counts while latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (streak_q != '0) |-> latch_q)
    else $error("fresh streak nonzero while not latched");

  // an accepted resume leaves the latch and goes live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && resume_ok) |=> (!latch_q && mode_q == ofg_pkg::MODE_LIVE && stale_q == '0))
    else $error("accepted resume did not release the latch");

  // a clear returns the guard to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && kind_i == ofg_pkg::KIND_CLEAR) |=>
      (!latch_q && !pose_cached_q && !ftv_q && mode_q == ofg_pkg::MODE_WAITING))
    else $error("clear left state behind");

  // state moves only with an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(mode_q) && $stable(latch_q) && $stable(last_q)))
    else $error("guard state changed without an item");

endmodule

### rtl/observation_freshness_guard_top.sv
// ----------------------------------------------------------------------------
// observation_freshness_guard_top
// Watchdog that judges the freshness of an external pose observation.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An input register feeds the guard update,
// and its status lands in a result register when that is free or read out;
// while a result waits, the input side stays open only if the input
// register is empty. Throughput is one beat per cycle when the result side
// does not stall, limited by the single guard update stage whose state is
// read and written in the same cycle. Configuration writes take effect at
// once and belong to periods when no beat is in flight.
module observation_freshness_guard_top #(
  parameter int unsigned TIME_BITS   = ofg_pkg::TIME_BITS_DEF,
  parameter int unsigned AGE_BITS    = ofg_pkg::AGE_BITS_DEF,
  parameter int unsigned STREAK_BITS = ofg_pkg::STREAK_BITS_DEF,
  // packed beat widths, rounded up to whole bytes
  localparam int unsigned InRaw  = TIME_BITS + 2 + AGE_BITS,
  localparam int unsigned InW    = ((InRaw + 7) / 8) * 8,
  localparam int unsigned OutRaw = 3 + AGE_BITS + STREAK_BITS + 3,
  localparam int unsigned OutW   = ((OutRaw + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [ofg_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [ofg_pkg::CFG_W-1:0]     cfg_wdata_i,
  // input beats
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_time, pose_present, age_valid, pose_age
  input  logic [InW-1:0]                s_axis_tdata_i,
  // kind
  input  logic [1:0]                    s_axis_tuser_i,
  // result beats
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // mode, stale_time, fresh_streak, latched, pose_held, resume_ok
  output logic [OutW-1:0]               m_axis_tdata_o
);

  logic [ofg_pkg::LIMIT_W-1:0] fresh_limit_q, fallback_limit_q;
  logic [ofg_pkg::RCNT_W-1:0]  recovery_count_q;

  logic                   in_vld_q, in_vld_d;
  logic [1:0]             kind_q;
  logic [TIME_BITS-1:0]   now_q;
  logic                   pp_q, av_q;
  logic [AGE_BITS-1:0]    age_q;

  logic                   out_vld_q, out_vld_d;
  logic [OutRaw-1:0]      out_q;

  logic                   in_fire, advance, en;
  ofg_pkg::mode_e         mode;
  logic [AGE_BITS-1:0]    stale;
  logic [STREAK_BITS-1:0] streak;
  ofg_pkg::flags_t        flags;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_limit_q    <= ofg_pkg::FRESH_LIMIT_RST;
      fallback_limit_q <= ofg_pkg::FALLBACK_LIMIT_RST;
      recovery_count_q <= ofg_pkg::RECOVERY_COUNT_RST;
    end else if (cfg_we_i) begin
      case (ofg_pkg::cfg_idx_e'(cfg_addr_i))
        ofg_pkg::CFG_FRESH_LIMIT:    fresh_limit_q    <= cfg_wdata_i[ofg_pkg::LIMIT_W-1:0];
        ofg_pkg::CFG_FALLBACK_LIMIT: fallback_limit_q <= cfg_wdata_i[ofg_pkg::LIMIT_W-1:0];
        ofg_pkg::CFG_RECOVERY_COUNT: recovery_count_q <= cfg_wdata_i[ofg_pkg::RCNT_W-1:0];
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // pipeline handshake
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign en              = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vld_d        = in_fire ? 1'b1 : (en ? 1'b0 : in_vld_q);
  assign out_vld_d       = en ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= s_axis_tuser_i;
      now_q  <= s_axis_tdata_i[TIME_BITS-1:0];
      pp_q   <= s_axis_tdata_i[TIME_BITS];
      av_q   <= s_axis_tdata_i[TIME_BITS+1];
      age_q  <= s_axis_tdata_i[TIME_BITS+2 +: AGE_BITS];
    end
  end

  ofg_core #(
    .TIME_BITS   (TIME_BITS),
    .AGE_BITS    (AGE_BITS),
    .STREAK_BITS (STREAK_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .kind_i           (kind_q),
    .now_time_i       (now_q),
    .pose_present_i   (pp_q),
    .age_valid_i      (av_q),
    .pose_age_i       (age_q),
    .fresh_limit_i    (fresh_limit_q),
    .fallback_limit_i (fallback_limit_q),
    .recovery_count_i (recovery_count_q),
    .mode_o           (mode),
    .stale_time_o     (stale),
    .fresh_streak_o   (streak),
    .flags_o          (flags)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {flags.resume_ok, flags.pose_held, flags.latched, streak, stale,
                3'(mode)};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'(out_q);

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the observation freshness guard. A clocked driver
// feeds update, resume, clear and unused-kind beats from a queue. A clocked
// monitor compares every result beat field by field against a guard model
// that the bench keeps beside the block. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ofg_pkg::*;

  localparam int unsigned TW     = TIME_BITS_DEF;
  localparam int unsigned AW     = AGE_BITS_DEF;
  localparam int unsigned SW     = STREAK_BITS_DEF;
  localparam int unsigned IN_W   = ((TW + 2 + AW + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((3 + AW + SW + 3 + 7) / 8) * 8;
  localparam int unsigned ST_LSB = 3;
  localparam int unsigned SK_LSB = ST_LSB + AW;
  localparam int unsigned LT_BIT = SK_LSB + SW;
  localparam int unsigned HD_BIT = LT_BIT + 1;
  localparam int unsigned OK_BIT = LT_BIT + 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_SHOWN   = 100;

  // kind code the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [AW-1:0] AGE_MAX   = '1;
  localparam logic [SW-1:0] STRK_MAX  = '1;

  typedef struct {
    logic [1:0]    kind;
    logic [TW-1:0] now;
    logic          pres;
    logic          aval;
    logic [AW-1:0] age;
  } obs_beat_t;

  typedef struct {
    mode_e         mode;
    logic [AW-1:0] stale;
    logic [SW-1:0] streak;
    logic          latched;
    logic          held;
    logic          ok;
  } guard_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i    = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr_i  = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [IN_W-1:0]     s_axis_tdata_i  = '0;
  logic [1:0]          s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata_o;

  observation_freshness_guard_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // beats waiting to be sent and status beats still owed by the block
  obs_beat_t     obs_pending[$];
  guard_status_t status_owed[$];

  int unsigned n_errors   = 0;
  int unsigned beats_in   = 0;
  int unsigned beats_out  = 0;
  int unsigned n_pushed   = 0;
  int unsigned n_settings = 1;
  int unsigned n_resumed  = 0;
  int unsigned cycles     = 0;
  logic [TW-1:0] now_t    = '0;

  // register mirror
  logic [AW-1:0] cfg_fresh_limit    = FRESH_LIMIT_RST;
  logic [AW-1:0] cfg_fallback_limit = FALLBACK_LIMIT_RST;
  logic [SW-1:0] cfg_recovery_count = RECOVERY_COUNT_RST;

  // guard state mirror
  logic          g_pose_cached = 1'b0;
  logic          g_fresh_valid = 1'b0;
  logic [TW-1:0] g_last_fresh  = '0;
  logic          g_latched     = 1'b0;
  logic [SW-1:0] g_streak      = '0;
  mode_e         g_mode        = MODE_WAITING;
  logic [AW-1:0] g_stale       = '0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [TW-1:0] got,
                                 input logic [TW-1:0] want);
    n_errors++;
    if (n_errors <= MAX_SHOWN)
      $display("mismatch at result %0d: %s got %0h expected %0h", beats_out, what, got,
               want);
  endtask

  // advance the guard model by one beat and return the status it reports
  function automatic guard_status_t guard_step(input obs_beat_t b);
    guard_status_t r;
    logic          fresh;
    logic          fb_en;
    logic [TW-1:0] age_w;
    logic [TW-1:0] stale_full;
    r.ok  = 1'b0;
    age_w = TW'(b.age);
    if (b.kind == KIND_UPDATE) begin
      fresh = b.pres && b.aval && (b.age <= cfg_fresh_limit);
      fb_en = cfg_fallback_limit != '0;
      if (b.pres) g_pose_cached = 1'b1;
      // first valid age seeds the fresh time even when too old
      if (fresh || (!g_fresh_valid && b.pres && b.aval)) begin
        g_last_fresh  = (age_w > b.now) ? '0 : b.now - age_w;
        g_fresh_valid = 1'b1;
      end
      if (g_fresh_valid)
        stale_full = (b.now >= g_last_fresh) ? b.now - g_last_fresh : '0;
      else
        stale_full = fb_en ? TW'(cfg_fallback_limit) : '0;
      g_stale = (stale_full > TW'(AGE_MAX)) ? AGE_MAX : stale_full[AW-1:0];
      if (g_latched) begin
        // count toward recovery while latched
        if (fresh) g_streak = (g_streak == STRK_MAX) ? STRK_MAX : g_streak + 1'b1;
        else g_streak = '0;
        g_mode = (g_streak >= cfg_recovery_count) ? MODE_RECOVERED : MODE_FALLBACK;
      end else begin
        g_streak = '0;
        if (fresh) begin
          g_mode = MODE_LIVE;
        end else if (g_pose_cached && (!fb_en || stale_full <= TW'(cfg_fallback_limit))) begin
          g_mode = MODE_HOLD;
        end else if (fb_en) begin
          g_latched = 1'b1;
          g_mode    = MODE_FALLBACK;
        end else begin
          g_mode = MODE_WAITING;
        end
      end
    end else if (b.kind == KIND_RESUME) begin
      if (g_latched && g_mode == MODE_RECOVERED) begin
        g_latched = 1'b0;
        g_streak  = '0;
        g_stale   = '0;
        g_mode    = MODE_LIVE;
        r.ok      = 1'b1;
      end
    end else if (b.kind == KIND_CLEAR) begin
      g_pose_cached = 1'b0;
      g_fresh_valid = 1'b0;
      g_last_fresh  = '0;
      g_latched     = 1'b0;
      g_streak      = '0;
      g_mode        = MODE_WAITING;
      g_stale       = '0;
    end
    r.mode    = g_mode;
    r.stale   = g_stale;
    r.streak  = g_streak;
    r.latched = g_latched;
    r.held    = g_pose_cached;
    return r;
  endfunction

  // input driver: holds a beat until taken, idles at random outside the quiet stretch
  always @(posedge clk_i) begin : obs_driver
    logic idle_ok;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        status_owed.push_back(guard_step(obs_pending[0]));
        obs_pending.pop_front();
        beats_in++;
      end
      idle_ok = !(beats_in >= 150 && beats_in < 260);
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (obs_pending.size() != 0 && !(idle_ok && $urandom_range(0, 99) < 33)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= obs_pending[0].kind;
          s_axis_tdata_i  <= {{(IN_W - TW - 2 - AW){1'b0}}, obs_pending[0].age,
                              obs_pending[0].aval, obs_pending[0].pres,
                              obs_pending[0].now};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each beat against the oldest owed status
  always @(posedge clk_i) begin : status_monitor
    guard_status_t got;
    guard_status_t want;
    logic          idle_ok;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.mode    = mode_e'(m_axis_tdata_o[2:0]);
        got.stale   = m_axis_tdata_o[ST_LSB +: AW];
        got.streak  = m_axis_tdata_o[SK_LSB +: SW];
        got.latched = m_axis_tdata_o[LT_BIT];
        got.held    = m_axis_tdata_o[HD_BIT];
        got.ok      = m_axis_tdata_o[OK_BIT];
        if (status_owed.size() == 0) begin
          report_mismatch("result beat with nothing owed", TW'(m_axis_tdata_o), '0);
        end else begin
          want = status_owed.pop_front();
          if (got.mode !== want.mode)
            report_mismatch("mode", TW'(got.mode), TW'(want.mode));
          if (got.stale !== want.stale)
            report_mismatch("stale_time", TW'(got.stale), TW'(want.stale));
          if (got.streak !== want.streak)
            report_mismatch("fresh_streak", TW'(got.streak), TW'(want.streak));
          if (got.latched !== want.latched)
            report_mismatch("latched", TW'(got.latched), TW'(want.latched));
          if (got.held !== want.held)
            report_mismatch("pose_held", TW'(got.held), TW'(want.held));
          if (got.ok !== want.ok)
            report_mismatch("resume_ok", TW'(got.ok), TW'(want.ok));
          if (want.ok) n_resumed++;
        end
        beats_out++;
      end
      idle_ok = !(beats_out >= 150 && beats_out < 260);
      m_axis_tready_i <= !(idle_ok && $urandom_range(0, 99) < 33);
    end
  end

  task automatic push_beat(input logic [1:0] k, input logic [TW-1:0] now, input logic pres,
                           input logic aval, input logic [AW-1:0] age);
    obs_beat_t b;
    b.kind = k;
    b.now  = now;
    b.pres = pres;
    b.aval = aval;
    b.age  = age;
    obs_pending.push_back(b);
    n_pushed++;
  endtask

  // register write; the caller lowers the enable after the last one
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_FRESH_LIMIT:    cfg_fresh_limit    = val[AW-1:0];
      CFG_FALLBACK_LIMIT: cfg_fallback_limit = val[AW-1:0];
      CFG_RECOVERY_COUNT: cfg_recovery_count = val[SW-1:0];
      default: ;
    endcase
  endtask

  // wait for the block to drain
  task automatic wait_drained();
    while (obs_pending.size() != 0 || status_owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_guard(input logic [CFG_W-1:0] fresh, input logic [CFG_W-1:0] fb,
                           input logic [CFG_W-1:0] rcnt);
    wait_drained();
    write_reg(CFG_FRESH_LIMIT, fresh);
    write_reg(CFG_FALLBACK_LIMIT, fb);
    write_reg(CFG_RECOVERY_COUNT, rcnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // fresh update a little later in time
  task automatic gen_fresh();
    logic [AW-1:0] scale;
    scale = (cfg_fallback_limit != '0) ? cfg_fallback_limit : AW'(1000);
    now_t = now_t + TW'($urandom_range(1, (scale >> 3) + 1));
    push_beat(KIND_UPDATE, now_t, 1'b1, 1'b1, $urandom_range(0, cfg_fresh_limit));
  endtask

  // stale update: no pose, invalid age or too old, with a step toward fallback
  task automatic gen_stale();
    logic [AW-1:0] half;
    int unsigned   pick;
    half = (cfg_fallback_limit != '0) ? (cfg_fallback_limit >> 1) : AW'(2500);
    if ($urandom_range(0, 9) == 0)
      now_t = now_t + {12'd0, 4'($urandom_range(1, 15)), 32'($urandom)};
    else
      now_t = now_t + TW'(half) + TW'($urandom_range(1, half + 1));
    pick = $urandom_range(0, 2);
    if (pick == 2 && cfg_fresh_limit == AGE_MAX) pick = 0;
    case (pick)
      0: push_beat(KIND_UPDATE, now_t, 1'b0, 1'($urandom), $urandom);
      1: push_beat(KIND_UPDATE, now_t, 1'b1, 1'b0, $urandom);
      default: push_beat(KIND_UPDATE, now_t, 1'b1, 1'b1,
                         $urandom_range(cfg_fresh_limit + 1, AGE_MAX));
    endcase
  endtask

  // optional clear, fresh run, stale run to latch, recovery run, resume, fresh tail
  task automatic gen_episode();
    int n_rec;
    if ($urandom_range(0, 5) == 0) push_beat(KIND_CLEAR, now_t, 1'($urandom), 1'($urandom),
                                              $urandom);
    repeat ($urandom_range(1, 4)) gen_fresh();
    repeat ($urandom_range(1, 6)) gen_stale();
    if ($urandom_range(0, 1) == 1) push_beat(KIND_RESUME, now_t, 1'($urandom),
                                              1'($urandom), $urandom);
    n_rec = int'(cfg_recovery_count) + int'($urandom_range(0, 2)) - 1;
    if (n_rec < 0) n_rec = 0;
    repeat (n_rec) begin
      if (cfg_recovery_count < 16 && $urandom_range(0, 9) == 0) gen_stale();
      else gen_fresh();
    end
    push_beat(KIND_RESUME, now_t, 1'($urandom), 1'($urandom), $urandom);
    repeat ($urandom_range(0, 3)) gen_fresh();
  endtask

  // mostly episodes, some raw noise with any kind and any time
  task automatic run_random(input int unsigned n);
    int unsigned start;
    start = n_pushed;
    while (n_pushed - start < n) begin
      if ($urandom_range(0, 99) < 80) begin
        gen_episode();
      end else begin
        repeat ($urandom_range(1, 3))
          push_beat(2'($urandom_range(0, 3)), TW'({$urandom, $urandom}), 1'($urandom),
                    1'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: fallback off, boundaries of age and time
    push_beat(KIND_UNUSED, '0, 1'b0, 1'b0, '0);
    push_beat(KIND_UPDATE, 48'd100, 1'b0, 1'b0, '0);
    push_beat(KIND_RESUME, 48'd100, 1'b0, 1'b0, '0);
    push_beat(KIND_UPDATE, 48'd1000, 1'b1, 1'b1, 32'd200000);
    push_beat(KIND_UPDATE, 48'd5000, 1'b1, 1'b1, '0);
    push_beat(KIND_UPDATE, 48'd200000, 1'b1, 1'b1, 32'd100000);
    push_beat(KIND_UPDATE, 48'd200010, 1'b1, 1'b0, 32'd5);
    push_beat(KIND_UPDATE, 48'd50, 1'b0, 1'b1, '0);
    push_beat(KIND_UPDATE, '1, 1'b0, 1'b0, '0);
    push_beat(KIND_UPDATE, '1, 1'b1, 1'b1, '1);
    push_beat(KIND_CLEAR, '0, 1'b0, 1'b0, '0);
    push_beat(KIND_UNUSED, '1, 1'b1, 1'b1, '1);

    // fallback on: latch, recovery, broken streak, resume refused and accepted
    set_guard(32'd100, 32'd1000, 32'd2);
    push_beat(KIND_UPDATE, 48'd10, 1'b0, 1'b0, '0);
    push_beat(KIND_RESUME, 48'd10, 1'b0, 1'b0, '0);
    push_beat(KIND_UPDATE, 48'd20, 1'b1, 1'b1, 32'd5);
    push_beat(KIND_UPDATE, 48'd30, 1'b1, 1'b1, 32'd100);
    push_beat(KIND_UPDATE, 48'd40, 1'b1, 1'b1, 32'd101);
    push_beat(KIND_UPDATE, 48'd50, 1'b1, 1'b1, '0);
    push_beat(KIND_UPDATE, 48'd60, 1'b1, 1'b1, 32'd3);
    push_beat(KIND_RESUME, 48'd60, 1'b0, 1'b0, '0);
    push_beat(KIND_RESUME, 48'd60, 1'b0, 1'b0, '0);
    push_beat(KIND_UPDATE, 48'd70, 1'b1, 1'b1, 32'd1);
    push_beat(KIND_UPDATE, 48'd3000, 1'b1, 1'b0, '0);
    push_beat(KIND_CLEAR, 48'd3000, 1'b0, 1'b0, '0);
    now_t = 48'd4000;

    // random phases over several settings, extremes among them
    set_guard(32'd100000, 32'd0, 32'd1);
    run_random(40);
    set_guard(32'd1000, 32'd5000, 32'd3);
    run_random(40);
    set_guard('1, '1, 32'd2);
    run_random(40);
    set_guard(32'd1, 32'd1, 32'd0);
    run_random(40);
    set_guard(32'd500, 32'd20, 32'd255);
    run_random(150);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (status_owed.size() != 0)
      report_mismatch("status beats never delivered", TW'(status_owed.size()), '0);

    $display("sent %0d beats under %0d register settings, checked %0d results",
             beats_in, n_settings, beats_out);
    $display("%0d resume requests were granted, %0d mismatches", n_resumed, n_errors);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ofg_pkg.sv
rtl/ofg_core.sv
rtl/observation_freshness_guard_top.sv
tb/sv/tb.sv
